FILE: hw/rtl/isk_pkg.sv
// shared types, constants and sha-256 helpers for the key derivation block
package isk_pkg;

	localparam int MaxPwUnits = 64;
	localparam int PwIdxW = $clog2(MaxPwUnits);
	localparam int PwCntW = $clog2(MaxPwUnits + 1);
	localparam logic [4:0] MaxCyclesPower = 5'd24;
	localparam logic [4:0] CyclesPowerReset = 5'd19;
	localparam int KeyWords = 4;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        unit_valid;
		logic        is_last;
	} in_item_t;

	typedef struct packed {
		logic [63:0] key_word;
		logic [1:0]  word_index;
		logic        last_word;
		logic        too_long;
	} out_item_t;

	// job handed from the front part to the derivation engine
	typedef struct packed {
		logic [PwCntW-1:0] n_units;
		logic              overflow;
	} job_t;

	typedef logic [31:0] word_t;

	localparam word_t RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam word_t ChainInit [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic word_t rotr(input word_t x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage

FILE: hw/rtl/iterated_sha256_key_derivation.sv
// top level of the iterated sha-256 key derivation block
// A password arrives as UTF-16 units, one per transaction; a transaction with is_last
// starts derivation of 2^cycles_power rounds (capped at 24) and yields four 64-bit key
// words. Cost is set by the single round unit: each password unit passes through the
// fetch, wait and high-byte states, each counter byte through the counter state, and
// each 64-byte block through 64 compression rounds, plus padding and four output words.
// Input is held off while a derivation runs.
module iterated_sha256_key_derivation (
	input  logic               clk,
	input  logic               arst_n,
	input  isk_pkg::in_item_t  in_data,
	input  logic               in_valid,
	output logic               in_ready,
	output isk_pkg::out_item_t out_data,
	output logic               out_valid,
	input  logic               out_ready,
	input  logic [4:0]         cfg_data,
	input  logic               cfg_valid,
	output logic               cfg_ready
);
	import isk_pkg::*;

	logic [4:0]        power_q;
	logic              job_valid, job_ready;
	job_t              job_data;
	logic [PwIdxW-1:0] rd_addr;
	logic [15:0]       rd_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) power_q <= CyclesPowerReset;
		else if (cfg_valid && cfg_ready) power_q <= cfg_data;
	end

	isk_front u_front (
		.clk, .arst_n, .in_data, .in_valid, .in_ready,
		.job_valid, .job_ready, .job_data, .rd_addr, .rd_data
	);

	isk_engine u_engine (
		.clk, .arst_n, .cycles_power(power_q), .job_valid, .job_ready, .job_data,
		.rd_addr, .rd_data, .out_data, .out_valid, .out_ready
	);

endmodule

FILE: hw/rtl/isk_front.sv
// front part: collects password units and posts derivation jobs
module isk_front (
	input  logic                clk,
	input  logic                arst_n,
	input  isk_pkg::in_item_t   in_data,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                job_valid,
	input  logic                job_ready,
	output isk_pkg::job_t       job_data,
	// store read port for the engine
	input  logic [isk_pkg::PwIdxW-1:0] rd_addr,
	output logic [15:0]                rd_data
);
	import isk_pkg::*;

	logic [15:0]       store_q [MaxPwUnits];
	logic [PwCntW-1:0] count_q;
	logic              ovf_q;
	logic              busy_q;
	logic              full;
	logic              acc;

	// the engine reads the store until it hands the result back
	assign full = (count_q == PwCntW'(MaxPwUnits));
	assign in_ready = !busy_q && !job_valid;
	assign acc = in_valid && in_ready;

	always_ff @(posedge clk) begin
		if (acc && in_data.unit_valid && !full) begin
			store_q[count_q[PwIdxW-1:0]] <= in_data.code_unit;
		end
		rd_data <= store_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			ovf_q     <= 1'b0;
			busy_q    <= 1'b0;
			job_valid <= 1'b0;
			job_data  <= '0;
		end else begin
			if (job_valid && job_ready) begin
				job_valid <= 1'b0;
				busy_q    <= 1'b1;
			end
			if (busy_q && job_ready && !job_valid) begin
				busy_q <= 1'b0;
			end
			if (acc) begin
				logic [PwCntW-1:0] nc;
				logic              no;
				nc = count_q;
				no = ovf_q;
				if (in_data.unit_valid) begin
					if (full) no = 1'b1;
					else nc = count_q + 1'b1;
				end
				if (in_data.is_last) begin
					job_valid <= 1'b1;
					job_data  <= '{n_units: nc, overflow: no};
					count_q   <= '0;
					ovf_q     <= 1'b0;
				end else begin
					count_q <= nc;
					ovf_q   <= no;
				end
			end
		end
	end

	// the job count field can never exceed the store size
	assert property (@(posedge clk) disable iff (!arst_n)
		job_valid |-> job_data.n_units <= PwCntW'(MaxPwUnits))
		else $error("job unit count beyond store");
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= PwCntW'(MaxPwUnits))
		else $error("unit count beyond store");
	assert property (@(posedge clk) disable iff (!arst_n)
		(job_valid && !job_ready) |=> job_valid && $stable(job_data))
		else $error("job dropped");

endmodule

FILE: hw/rtl/isk_engine.sv
// back part: byte stream generator, sha-256 round unit and result output
module isk_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [4:0]          cycles_power,
	input  logic                job_valid,
	output logic                job_ready,
	input  isk_pkg::job_t       job_data,
	output logic [isk_pkg::PwIdxW-1:0] rd_addr,
	input  logic [15:0]         rd_data,
	output isk_pkg::out_item_t  out_data,
	output logic                out_valid,
	input  logic                out_ready
);
	import isk_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_FETCH, S_WAIT, S_HI, S_CNT, S_PAD80, S_PADZ, S_LEN, S_COMP, S_OUT
	} state_t;

	state_t            state_q;
	state_t            ret_q;
	job_t              job_q;
	logic [PwCntW-1:0] idx_q;
	logic [24:0]       round_q;
	logic [24:0]       last_round_q;
	logic [2:0]        cnt_q;
	logic [63:0]       bits_q;
	logic [5:0]        fill_q;
	logic [7:0]        hi_q;
	word_t             blk_q [16];
	word_t             h_q [8];
	word_t             a_q, b_q, c_q, d_q, e_q, f_q, g_q, hh_q;
	logic [5:0]        rnd_q;
	logic [1:0]        k_q;

	logic [7:0] byte_d;
	logic       byte_en;
	logic [7:0] lenb;
	word_t      w_new, s0, s1, t1, t2;

	assign rd_addr = idx_q[PwIdxW-1:0];
	assign job_ready = (state_q == S_IDLE);

	always_comb begin
		lenb = bits_q[63:56];
		byte_en = 1'b0;
		byte_d  = '0;
		case (state_q)
			S_WAIT:  begin byte_en = 1'b1; byte_d = rd_data[7:0]; end
			S_HI:    begin byte_en = 1'b1; byte_d = hi_q; end
			S_CNT:   begin
				byte_en = 1'b1;
				byte_d  = (cnt_q[2] == 1'b0) ? 8'(({7'd0, round_q} >> {cnt_q[1:0], 3'd0})) : 8'd0;
			end
			S_PAD80: begin byte_en = 1'b1; byte_d = 8'h80; end
			S_PADZ:  begin byte_en = 1'b1; byte_d = 8'h00; end
			S_LEN:   begin byte_en = 1'b1; byte_d = lenb; end
			default: ;
		endcase
		s0 = rotr(blk_q[1], 7) ^ rotr(blk_q[1], 18) ^ (blk_q[1] >> 3);
		s1 = rotr(blk_q[14], 17) ^ rotr(blk_q[14], 19) ^ (blk_q[14] >> 10);
		w_new = blk_q[0] + s0 + blk_q[9] + s1;
		t1 = hh_q + (rotr(e_q, 6) ^ rotr(e_q, 11) ^ rotr(e_q, 25))
			+ ((e_q & f_q) ^ (~e_q & g_q)) + RoundK[rnd_q] + blk_q[0];
		t2 = (rotr(a_q, 2) ^ rotr(a_q, 13) ^ rotr(a_q, 22))
			+ ((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));
	end

	always_ff @(posedge clk) begin
		if (byte_en) begin
			blk_q[fill_q[5:2]] <= (blk_q[fill_q[5:2]]
				& ~(32'hff << {~fill_q[1:0], 3'd0})) | ({24'd0, byte_d} << {~fill_q[1:0], 3'd0});
		end else if (state_q == S_COMP) begin
			// schedule as a shifting window, w[i] at the front
			for (int i = 0; i < 15; i++) blk_q[i] <= blk_q[i + 1];
			blk_q[15] <= w_new;
		end
		if (state_q == S_WAIT) hi_q <= rd_data[15:8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_IDLE;
			job_q <= '0;
			idx_q <= '0;
			round_q <= '0;
			last_round_q <= '0;
			cnt_q <= '0;
			bits_q <= '0;
			fill_q <= '0;
			rnd_q <= '0;
			k_q <= '0;
			out_valid <= 1'b0;
			out_data <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= ChainInit[i];
			{a_q, b_q, c_q, d_q, e_q, f_q, g_q, hh_q} <= '0;
		end else begin
			if (byte_en) begin
				fill_q <= fill_q + 1'b1;
				if (state_q != S_PAD80 && state_q != S_PADZ && state_q != S_LEN)
					bits_q <= bits_q + 64'd8;
				if (state_q == S_LEN) bits_q <= {bits_q[55:0], 8'd0};
			end
			unique case (state_q)
				S_IDLE: if (job_valid) begin
					job_q <= job_data;
					for (int i = 0; i < 8; i++) h_q[i] <= ChainInit[i];
					fill_q <= '0;
					bits_q <= '0;
					round_q <= '0;
					last_round_q <= 25'((26'd1 << ((cycles_power > MaxCyclesPower)
						? MaxCyclesPower : cycles_power)) - 26'd1);
					idx_q <= '0;
					cnt_q <= '0;
					state_q <= (job_data.n_units == '0) ? S_CNT : S_FETCH;
				end
				S_FETCH: state_q <= S_WAIT;
				S_WAIT: begin
					idx_q <= idx_q + 1'b1;
					state_q <= S_HI;
					if (fill_q == 6'd63) begin ret_q <= S_HI; state_q <= S_COMP; end
				end
				S_HI: begin
					state_q <= (idx_q == job_q.n_units) ? S_CNT : S_FETCH;
					if (fill_q == 6'd63) begin
						ret_q <= (idx_q == job_q.n_units) ? S_CNT : S_FETCH;
						state_q <= S_COMP;
					end
				end
				S_CNT: begin
					logic done_r;
					state_t nx;
					cnt_q <= cnt_q + 1'b1;
					done_r = (round_q == last_round_q);
					nx = S_CNT;
					if (cnt_q == 3'd7) begin
						round_q <= round_q + 1'b1;
						idx_q <= '0;
						nx = done_r ? S_PAD80 : ((job_q.n_units == '0) ? S_CNT : S_FETCH);
					end
					state_q <= nx;
					if (fill_q == 6'd63) begin ret_q <= nx; state_q <= S_COMP; end
				end
				S_PAD80: begin
					state_q <= (fill_q == 6'd55) ? S_LEN : S_PADZ;
					if (fill_q == 6'd63) begin ret_q <= S_PADZ; state_q <= S_COMP; end
				end
				S_PADZ: begin
					state_q <= (fill_q == 6'd55) ? S_LEN : S_PADZ;
					cnt_q <= '0;
					if (fill_q == 6'd63) begin ret_q <= S_PADZ; state_q <= S_COMP; end
				end
				S_LEN: begin
					cnt_q <= cnt_q + 1'b1;
					if (fill_q == 6'd63) begin ret_q <= S_OUT; state_q <= S_COMP; end
				end
				S_COMP: begin
					rnd_q <= rnd_q + 1'b1;
					{a_q, b_q, c_q, d_q, e_q, f_q, g_q, hh_q}
						<= {t1 + t2, a_q, b_q, c_q, d_q + t1, e_q, f_q, g_q};
					if (rnd_q == 6'd63) begin
						h_q[0] <= h_q[0] + t1 + t2; h_q[1] <= h_q[1] + a_q;
						h_q[2] <= h_q[2] + b_q;     h_q[3] <= h_q[3] + c_q;
						h_q[4] <= h_q[4] + d_q + t1; h_q[5] <= h_q[5] + e_q;
						h_q[6] <= h_q[6] + f_q;     h_q[7] <= h_q[7] + g_q;
						state_q <= ret_q;
						k_q <= '0;
					end
				end
				S_OUT: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						out_data <= '{key_word: {h_q[{k_q, 1'b0}], h_q[{k_q, 1'b1}]},
							word_index: k_q, last_word: (k_q == 2'd3),
							too_long: job_q.overflow};
						k_q <= k_q + 1'b1;
						if (k_q == 2'd3) state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (out_valid && out_ready && !(state_q == S_OUT)) out_valid <= 1'b0;
			// load working variables when a block fills
			if (state_q != S_COMP && byte_en && fill_q == 6'd63) begin
				{a_q, b_q, c_q, d_q, e_q, f_q, g_q, hh_q}
					<= {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4], h_q[5], h_q[6], h_q[7]};
				rnd_q <= '0;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMP) |-> !byte_en)
		else $error("byte written during compression");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.last_word) |-> out_data.word_index == 2'd3)
		else $error("last flag off final word");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LEN) |-> fill_q >= 6'd56)
		else $error("length outside final block slot");

endmodule
